// ===== design/coalescing_can_tx_queue_top_macros.svh =====
// Assertion helpers used by the queue's controller RTL (cctq_ctrl.sv).
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef COALESCING_CAN_TX_QUEUE_TOP_MACROS_SVH
`define COALESCING_CAN_TX_QUEUE_TOP_MACROS_SVH

// Property checked on every rising edge while out of reset.
`define CCTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Antecedent in one cycle implies the consequent in the next one.
`define CCTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cctq_pkg.sv =====
`default_nettype none

package cctq_pkg;

  localparam int HDR_W  = 64;
  localparam int ID_W   = 32;
  localparam int MODE_W = 32;
  localparam int LEN_W  = 7;
  localparam int WORD_W = 64;
  localparam int WORDS  = 8;
  localparam int WSEL_W = 3;
  localparam int STAT_W = 3;

  localparam logic [LEN_W-1:0] MAX_LEN = 7'd64;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_FULL     = 3'd0;
  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_ENQUEUED = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_DEQUEUED = 3'd4;

  typedef struct packed {
    logic              op;
    logic [HDR_W-1:0]  in_header;
    logic [MODE_W-1:0] in_mode;
    logic [LEN_W-1:0]  in_length;
    logic [WORD_W-1:0] in_word_0;
    logic [WORD_W-1:0] in_word_1;
    logic [WORD_W-1:0] in_word_2;
    logic [WORD_W-1:0] in_word_3;
    logic [WORD_W-1:0] in_word_4;
    logic [WORD_W-1:0] in_word_5;
    logic [WORD_W-1:0] in_word_6;
    logic [WORD_W-1:0] in_word_7;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [HDR_W-1:0]  out_header;
    logic [MODE_W-1:0] out_mode;
    logic [LEN_W-1:0]  out_length;
    logic [WORD_W-1:0] out_word_0;
    logic [WORD_W-1:0] out_word_1;
    logic [WORD_W-1:0] out_word_2;
    logic [WORD_W-1:0] out_word_3;
    logic [WORD_W-1:0] out_word_4;
    logic [WORD_W-1:0] out_word_5;
    logic [WORD_W-1:0] out_word_6;
    logic [WORD_W-1:0] out_word_7;
  } out_item_t;

  // One entry of the key store: everything of a slot except its payload.
  typedef struct packed {
    logic [HDR_W-1:0]  hdr;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  len;
  } key_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } ctrl_sts_t;

  function automatic logic [WORD_W-1:0] in_word(input in_item_t it,
                                                input logic [WSEL_W-1:0] w);
    logic [WORD_W-1:0] d;
    unique case (w)
      3'd0: d = it.in_word_0;
      3'd1: d = it.in_word_1;
      3'd2: d = it.in_word_2;
      3'd3: d = it.in_word_3;
      3'd4: d = it.in_word_4;
      3'd5: d = it.in_word_5;
      3'd6: d = it.in_word_6;
      3'd7: d = it.in_word_7;
    endcase
    return d;
  endfunction

  function automatic out_item_t put_word(input out_item_t r, input logic [WSEL_W-1:0] w,
                                         input logic [WORD_W-1:0] d);
    out_item_t o;
    o = r;
    unique case (w)
      3'd0: o.out_word_0 = d;
      3'd1: o.out_word_1 = d;
      3'd2: o.out_word_2 = d;
      3'd3: o.out_word_3 = d;
      3'd4: o.out_word_4 = d;
      3'd5: o.out_word_5 = d;
      3'd6: o.out_word_6 = d;
      3'd7: o.out_word_7 = d;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== design/cctq_ram.sv =====
`default_nettype none

module cctq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/cctq_ctrl.sv =====
`default_nettype none
`include "coalescing_can_tx_queue_top_macros.svh"

module cctq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  localparam int IDX_W = $clog2(QUEUE_DEPTH),
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1),
  localparam int PAW = IDX_W + 3
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire cctq_pkg::in_item_t  start_item,
  input  wire logic                res_ack,
  output cctq_pkg::ctrl_sts_t      sts,
  output cctq_pkg::out_item_t      res,
  output logic                     key_we,
  output logic [IDX_W-1:0]         key_waddr,
  output cctq_pkg::key_t           key_wdata,
  output logic                     key_re,
  output logic [IDX_W-1:0]         key_raddr,
  input  wire cctq_pkg::key_t      key_rdata,
  output logic                     pay_we,
  output logic [PAW-1:0]           pay_waddr,
  output logic [63:0]              pay_wdata,
  output logic                     pay_re,
  output logic [PAW-1:0]           pay_raddr,
  input  wire logic [63:0]         pay_rdata
);

  import cctq_pkg::*;

  localparam int CNT_W = 4;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] LAST_READ = CNT_W'(WORDS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_WRITE  = 5'b00100,
    S_READ   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  out_item_t        res_r, res_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [OCC_W-1:0] rd_left_r, rd_left_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             append_r, append_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic              hit;
  logic [LEN_W-1:0]  base;
  logic [WORD_W-1:0] raw_word;
  logic [WORD_W-1:0] masked_word;
  logic [WSEL_W-1:0] rd_word;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  // Key compare against the entry read in the previous cycle.
  assign hit = pend_r && (key_rdata.hdr[ID_W-1:0] == item_r.in_header[ID_W-1:0]) &&
               (key_rdata.mode == item_r.in_mode);

  // Shared byte masker: keeps the bytes of the current word that lie below the length.
  assign base     = {1'b0, cnt_r[WSEL_W-1:0], 3'b000};
  assign raw_word = in_word(item_r, cnt_r[WSEL_W-1:0]);
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      masked_word[8*b +: 8] = ((base + LEN_W'(b)) < item_r.in_length) ? raw_word[8*b +: 8]
                                                                        : 8'h00;
    end
  end

  assign rd_word = WSEL_W'(cnt_r - 4'd1);

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    res_nxt     = res_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    occ_nxt     = occ_r;
    rd_idx_nxt  = rd_idx_r;
    rd_left_nxt = rd_left_r;
    pend_nxt    = pend_r;
    cmp_idx_nxt = cmp_idx_r;
    slot_nxt    = slot_r;
    append_nxt  = append_r;
    cnt_nxt     = cnt_r;

    key_we    = 1'b0;
    key_waddr = tail_r;
    key_wdata = '{hdr: item_r.in_header, mode: item_r.in_mode, len: item_r.in_length};
    key_re    = 1'b0;
    key_raddr = rd_idx_r;
    pay_we    = 1'b0;
    pay_waddr = {slot_r, cnt_r[WSEL_W-1:0]};
    pay_wdata = masked_word;
    pay_re    = 1'b0;
    pay_raddr = {head_r, cnt_r[WSEL_W-1:0]};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = start_item;
          if (start_item.in_length > MAX_LEN) begin
            item_nxt.in_length = MAX_LEN;
          end
          res_nxt  = '0;
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
          if (start_item.op == OP_ADD) begin
            rd_idx_nxt  = head_r;
            rd_left_nxt = occ_r;
            state_nxt   = S_SEARCH;
          end else if (occ_r == '0) begin
            res_nxt.status = ST_EMPTY;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      S_SEARCH: begin
        // Reads run one slot ahead of the compare.
        if (rd_left_r != '0) begin
          key_re      = 1'b1;
          rd_idx_nxt  = next_idx(rd_idx_r);
          rd_left_nxt = rd_left_r - 1'b1;
          pend_nxt    = 1'b1;
          cmp_idx_nxt = rd_idx_r;
        end else begin
          pend_nxt = 1'b0;
        end
        if (hit) begin
          // The stored header and mode stay; only the key's length field is refreshed.
          key_we         = 1'b1;
          key_waddr      = cmp_idx_r;
          key_wdata      = '{hdr: key_rdata.hdr, mode: key_rdata.mode,
                             len: item_r.in_length};
          slot_nxt       = cmp_idx_r;
          append_nxt     = 1'b0;
          res_nxt.status = ST_UPDATED;
          state_nxt      = S_WRITE;
        end else if (rd_left_r == '0) begin
          if (occ_r == FULL_OCC) begin
            res_nxt.status = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            key_we         = 1'b1;
            key_waddr      = tail_r;
            slot_nxt       = tail_r;
            append_nxt     = 1'b1;
            res_nxt.status = ST_ENQUEUED;
            state_nxt      = S_WRITE;
          end
        end
      end

      S_WRITE: begin
        pay_we = 1'b1;
        if (cnt_r[WSEL_W-1:0] == 3'd7) begin
          if (append_r) begin
            tail_nxt = next_idx(tail_r);
            occ_nxt  = occ_r + 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end

      S_READ: begin
        if (cnt_r != LAST_READ) begin
          pay_re = 1'b1;
        end
        if (cnt_r == '0) begin
          key_re    = 1'b1;
          key_raddr = head_r;
        end else begin
          res_nxt = put_word(res_r, rd_word, pay_rdata);
        end
        if (cnt_r == LAST_READ) begin
          res_nxt.status     = ST_DEQUEUED;
          res_nxt.out_header = key_rdata.hdr;
          res_nxt.out_mode   = key_rdata.mode;
          res_nxt.out_length = key_rdata.len;
          head_nxt           = next_idx(head_r);
          occ_nxt            = occ_r - 1'b1;
          state_nxt          = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end

      S_DONE: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      occ_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    res_r     <= res_nxt;
    rd_idx_r  <= rd_idx_nxt;
    rd_left_r <= rd_left_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    slot_r    <= slot_nxt;
    append_r  <= append_nxt;
    cnt_r     <= cnt_nxt;
  end

  assign sts.idle      = (state_r == S_IDLE);
  assign sts.res_valid = (state_r == S_DONE);
  assign res           = res_r;

  `CCTQ_ASSERT(a_empty_ptrs, (occ_r == '0) |-> (head_r == tail_r), "empty queue with split pointers")
  `CCTQ_ASSERT(a_read_nonempty, (state_r == S_READ) |-> (occ_r != '0), "dequeue from empty queue")
  `CCTQ_ASSERT_NEXT(a_start_busy, start && sts.idle, state_r != S_IDLE, "accepted item was dropped")
  `CCTQ_ASSERT_NEXT(a_done_hold, (state_r == S_DONE) && !res_ack, (state_r == S_DONE) && $stable(res_r), "pending result lost")

endmodule

`default_nettype wire

// ===== design/coalescing_can_tx_queue_top.sv =====
// Coalescing CAN transmit queue: ring FIFO of messages with replacement by key.
// An add runs a key search that reads one slot per cycle from the key RAM's single
// read port, then eight payload words are written one per cycle. A dequeue does eight
// payload RAM reads; a dequeue from an empty queue goes straight to the result.
// One item at a time; the next input is taken while a result waits in the output register.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
`default_nettype none

module coalescing_can_tx_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cctq_pkg::in_item_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cctq_pkg::out_item_t out_data
);

  import cctq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int PAW   = IDX_W + 3;

  ctrl_sts_t        sts;
  out_item_t        res;
  logic             start;
  logic             res_ack;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;

  logic             key_we;
  logic [IDX_W-1:0] key_waddr;
  key_t             key_wdata;
  logic             key_re;
  logic [IDX_W-1:0] key_raddr;
  key_t             key_rdata;
  logic             pay_we;
  logic [PAW-1:0]   pay_waddr;
  logic [63:0]      pay_wdata;
  logic             pay_re;
  logic [PAW-1:0]   pay_raddr;
  logic [63:0]      pay_rdata;

  assign in_ready = sts.idle;
  assign start    = in_valid && in_ready;
  // A finished result moves to the output register once that register is free.
  assign res_ack  = sts.res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ack) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cctq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .start_item (in_data),
    .res_ack    (res_ack),
    .sts        (sts),
    .res        (res),
    .key_we     (key_we),
    .key_waddr  (key_waddr),
    .key_wdata  (key_wdata),
    .key_re     (key_re),
    .key_raddr  (key_raddr),
    .key_rdata  (key_rdata),
    .pay_we     (pay_we),
    .pay_waddr  (pay_waddr),
    .pay_wdata  (pay_wdata),
    .pay_re     (pay_re),
    .pay_raddr  (pay_raddr),
    .pay_rdata  (pay_rdata)
  );

  cctq_ram #(
    .WIDTH($bits(key_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  cctq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(QUEUE_DEPTH * WORDS)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .re    (pay_re),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

endmodule

`default_nettype wire

// ===== dv/cctq_reply_monitor.sv =====
`timescale 1ns / 1ps

module cctq_reply_monitor #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  cctq_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  cctq_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count
);

  import cctq_pkg::*;

  // Shadow copy of the ring: keys, lengths and masked payload words per slot.
  logic [HDR_W-1:0]  shadow_hdr   [DEPTH];
  logic [MODE_W-1:0] shadow_mode  [DEPTH];
  logic [LEN_W-1:0]  shadow_len   [DEPTH];
  logic [WORD_W-1:0] shadow_words [DEPTH][WORDS];
  int shadow_head;
  int shadow_tail;
  int shadow_count;
  int reply_number;

  out_item_t awaited_replies[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    shadow_head   = 0;
    shadow_tail   = 0;
    shadow_count  = 0;
    reply_number  = 0;
  end

  function automatic logic [WORD_W-1:0] keep_bytes(input logic [WORD_W-1:0] w,
                                                   input int k, input int len);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      if (k * 8 + b < len) r[b*8 +: 8] = w[b*8 +: 8];
    end
    return r;
  endfunction

  // Applies one transfer to the shadow ring and returns the reply it must produce.
  function automatic out_item_t apply_queue_op(input in_item_t m);
    out_item_t r;
    logic [WORDS-1:0][WORD_W-1:0] iw;
    logic [WORDS-1:0][WORD_W-1:0] ow;
    int len;
    int idx;
    bit hit;
    r   = '0;
    ow  = '0;
    hit = 1'b0;
    iw  = {m.in_word_7, m.in_word_6, m.in_word_5, m.in_word_4,
           m.in_word_3, m.in_word_2, m.in_word_1, m.in_word_0};
    len = (m.in_length > MAX_LEN) ? int'(MAX_LEN) : int'(m.in_length);
    if (m.op == OP_ADD) begin
      idx = shadow_head;
      for (int i = 0; i < shadow_count; i++) begin
        if (!hit && shadow_hdr[idx][ID_W-1:0] == m.in_header[ID_W-1:0] &&
            shadow_mode[idx] == m.in_mode) begin
          hit = 1'b1;
          shadow_len[idx] = LEN_W'(len);
          for (int k = 0; k < WORDS; k++) shadow_words[idx][k] = keep_bytes(iw[k], k, len);
        end
        if (!hit) idx = (idx + 1) % DEPTH;
      end
      if (hit) begin
        r.status = ST_UPDATED;
      end else if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        idx = shadow_tail;
        shadow_hdr[idx]  = m.in_header;
        shadow_mode[idx] = m.in_mode;
        shadow_len[idx]  = LEN_W'(len);
        for (int k = 0; k < WORDS; k++) shadow_words[idx][k] = keep_bytes(iw[k], k, len);
        shadow_tail  = (shadow_tail + 1) % DEPTH;
        shadow_count = shadow_count + 1;
        r.status = ST_ENQUEUED;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      idx = shadow_head;
      r.status     = ST_DEQUEUED;
      r.out_header = shadow_hdr[idx];
      r.out_mode   = shadow_mode[idx];
      r.out_length = shadow_len[idx];
      for (int k = 0; k < WORDS; k++) ow[k] = shadow_words[idx][k];
      {r.out_word_7, r.out_word_6, r.out_word_5, r.out_word_4,
       r.out_word_3, r.out_word_2, r.out_word_1, r.out_word_0} = ow;
      shadow_head  = (shadow_head + 1) % DEPTH;
      shadow_count = shadow_count - 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    fail_count = fail_count + 1;
    $display("%0t reply %0d %s: got %h, wanted %h", $time, reply_number, what, got, want);
  endtask

  task automatic compare_reply(input out_item_t got, input out_item_t want);
    logic [WORDS-1:0][WORD_W-1:0] gw;
    logic [WORDS-1:0][WORD_W-1:0] ww;
    gw = {got.out_word_7, got.out_word_6, got.out_word_5, got.out_word_4,
          got.out_word_3, got.out_word_2, got.out_word_1, got.out_word_0};
    ww = {want.out_word_7, want.out_word_6, want.out_word_5, want.out_word_4,
          want.out_word_3, want.out_word_2, want.out_word_1, want.out_word_0};
    if (got.status !== want.status)
      report_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
    if (got.out_header !== want.out_header)
      report_mismatch("header", got.out_header, want.out_header);
    if (got.out_mode !== want.out_mode)
      report_mismatch("mode", WORD_W'(got.out_mode), WORD_W'(want.out_mode));
    if (got.out_length !== want.out_length)
      report_mismatch("length", WORD_W'(got.out_length), WORD_W'(want.out_length));
    for (int k = 0; k < WORDS; k++) begin
      if (gw[k] !== ww[k]) report_mismatch($sformatf("word %0d", k), gw[k], ww[k]);
    end
  endtask

  // The reply is taken before the new request is applied: a reply can never
  // belong to a request transferred at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("unexpected reply", WORD_W'(out_data.status), '0);
        end else begin
          compare_reply(out_data, awaited_replies.pop_front());
        end
        reply_number = reply_number + 1;
      end
      if (in_valid && in_ready) awaited_replies.push_back(apply_queue_op(in_data));
    end
    pending_count <= awaited_replies.size();
  end

endmodule

// ===== dv/tb_coalescing_can_tx_queue_top.sv =====
`timescale 1ns / 1ps

module tb_coalescing_can_tx_queue_top;
  import cctq_pkg::*;

  localparam int DEPTH             = 16;
  localparam int PHASE_ITEMS       = 450;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int DRAIN_CYCLES      = 40;
  localparam int CYCLE_LIMIT       = 1000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending_count;
  int unsigned cycle_count = 0;

  int idle_pct = 0;
  int stall_pct = 0;
  bit long_stall_req = 1'b0;

  always #5 clk = ~clk;

  coalescing_can_tx_queue_top #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  cctq_reply_monitor #(.DEPTH(DEPTH)) u_reply_monitor (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off that lets the queue back up.
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL_CYCLES - 1) @(posedge clk);
        long_stall_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(input in_item_t m);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic in_item_t add_msg(input logic [HDR_W-1:0] hdr,
                                       input logic [MODE_W-1:0] mode,
                                       input logic [LEN_W-1:0] len,
                                       input logic [WORD_W-1:0] fill);
    in_item_t m;
    m = '0;
    m.op        = OP_ADD;
    m.in_header = hdr;
    m.in_mode   = mode;
    m.in_length = len;
    {m.in_word_7, m.in_word_6, m.in_word_5, m.in_word_4,
     m.in_word_3, m.in_word_2, m.in_word_1, m.in_word_0} = {WORDS{fill}};
    return m;
  endfunction

  function automatic in_item_t random_msg(input int deq_pct);
    in_item_t m;
    m.op        = ($urandom_range(99) < deq_pct) ? OP_DEQ : OP_ADD;
    m.in_header = {$urandom(), $urandom()};
    m.in_mode   = $urandom();
    // Most keys come from a small set so that replacements and a full ring happen often.
    if ($urandom_range(9) < 8) begin
      m.in_header[ID_W-1:0] = {{30{1'($urandom_range(1))}}, 2'($urandom_range(3))};
      case ($urandom_range(2))
        0:       m.in_mode = '0;
        1:       m.in_mode = 32'h0000_0001;
        default: m.in_mode = '1;
      endcase
    end
    if ($urandom_range(9) == 0) m.in_length = LEN_W'($urandom_range(127, 65));
    else m.in_length = LEN_W'($urandom_range(64));
    {m.in_word_7, m.in_word_6, m.in_word_5, m.in_word_4,
     m.in_word_3, m.in_word_2, m.in_word_1, m.in_word_0} =
      {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
       $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
       $urandom(), $urandom(), $urandom(), $urandom()};
    return m;
  endfunction

  task automatic run_directed();
    in_item_t deq;
    deq = random_msg(100);
    send_item(deq);
    send_item(add_msg('0, '0, 7'd0, '1));
    send_item(add_msg('1, '1, MAX_LEN, '1));
    send_item(add_msg({$urandom(), 32'h0000_0055}, 32'd5, 7'd127, {$urandom(), $urandom()}));
    // Same key as the first message with new attributes; the stored header must survive.
    send_item(add_msg({32'hDEAD_BEEF, 32'h0}, '0, 7'd3, 64'hA5A5_A5A5_A5A5_A5A5));
    send_item(deq);
    for (int i = 0; i < DEPTH - 2; i++)
      send_item(add_msg({$urandom(), 32'h100 + i}, 32'd7, LEN_W'(i * 4 + 9),
                        {$urandom(), $urandom()}));
    send_item(add_msg({$urandom(), 32'h0000_0200}, 32'd7, 7'd8, '1));
    send_item(add_msg({$urandom(), 32'h100 + DEPTH - 3}, 32'd7, 7'd17, '1));
    send_item(deq);
  endtask

  initial begin
    int deq_pct;
    deq_pct = 50;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) deq_pct = 25 * (1 + $urandom_range(2));
        if (ph == 0 && n == 120) long_stall_req = 1'b1;
        send_item(random_msg(deq_pct));
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/cctq_pkg.sv
design/cctq_ram.sv
design/cctq_ctrl.sv
design/coalescing_can_tx_queue_top.sv
dv/cctq_reply_monitor.sv
dv/tb_coalescing_can_tx_queue_top.sv
